[src/pcrc_pkg.sv]
// ----------------------------------------------------------------------------
// pcrc_pkg
// Shared types and constants for the programmable bit-serial CRC.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcrc_pkg;

	localparam int unsigned REM_W   = 32;
	localparam int unsigned DEG_W   = 6;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [REM_W-1:0] POLY_RESET   = 32'h04C1_1DB7;
	localparam logic [DEG_W-1:0] DEGREE_RESET = 6'd32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GENERATOR_POLY = 1'b0,
		CFG_CRC_DEGREE     = 1'b1
	} cfg_reg_t;

	// broadcast to every cell of the remainder chain
	typedef struct packed {
		logic en;   // a request is taken this cycle
		logic clr;  // final bit: clear after the update
		logic fb;   // feedback = top remainder bit ^ data bit
	} cell_ctrl_t;

endpackage

`default_nettype wire

[src/pcrc_cell.sv]
// ----------------------------------------------------------------------------
// pcrc_cell
// One remainder bit: shifts in from its lower neighbor, XORs in its generator
// bit on feedback, and drops out when its index is at or above the active degree.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcrc_cell
	import pcrc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cell_ctrl_t ctrl,
	input  wire logic       poly_bit,
	input  wire logic       mask_bit,
	input  wire logic       shift_in,
	output logic            rem_bit,
	output logic            next_bit
);

	logic bit_q;

	assign rem_bit  = bit_q & mask_bit;
	assign next_bit = mask_bit & (shift_in ^ (ctrl.fb & poly_bit));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= 1'b0;
		end else if (ctrl.en) begin
			bit_q <= ctrl.clr ? 1'b0 : next_bit;
		end
	end

endmodule

`default_nettype wire

[src/programmable_crc_bit_serial.sv]
// ----------------------------------------------------------------------------
// programmable_crc_bit_serial
// Bit-serial CRC with programmable generator polynomial and degree.
// ----------------------------------------------------------------------------
// The block takes one message bit per clock, most significant first, and
// keeps the running remainder in a chain of one-bit cells, one per remainder
// bit, that all update in the same cycle. A request with tlast set produces
// one result (remainder and a zero flag) in the output register on the next
// edge, and the remainder clears for the next message. Sustained rate is one
// bit per cycle; the only stall is a full output register held by the sink.
// Register 0 is the generator below its implied top bit, register 1 the
// degree (0 acts as 1, values above min(MAX_DEGREE, 32) saturate).
`timescale 1ns / 1ps
`default_nettype none

module programmable_crc_bit_serial
	import pcrc_pkg::*;
#(
	parameter int unsigned MAX_DEGREE = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [REM_W-1:0]     cfg_wdata,
	// input stream
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [7:0]           s_axis_tdata,   // [0] data_bit, [7:1] zero
	input  wire logic                 s_axis_tlast,   // last_bit
	// result stream
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic [REM_W-1:0]          m_axis_tdata,   // [31:0] remainder
	output logic [0:0]                m_axis_tuser    // [0] remainder_zero
);

	localparam int unsigned NCELL = (MAX_DEGREE < REM_W) ? MAX_DEGREE : REM_W;
	localparam int unsigned IDX_W = (NCELL > 1) ? $clog2(NCELL) : 1;
	localparam logic [DEG_W-1:0] NCELL_D = DEG_W'(NCELL);

	logic [REM_W-1:0] poly_q;
	logic [DEG_W-1:0] degree_q;
	logic [DEG_W-1:0] deg_eff;
	logic [DEG_W-1:0] top_idx;
	logic [NCELL-1:0] mask;
	logic [NCELL-1:0] rem_vec;
	logic [NCELL-1:0] next_vec;
	logic             accept;
	cell_ctrl_t       ctrl;

	logic             out_valid_q;
	logic [REM_W-1:0] out_rem_q;
	logic             out_zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q   <= POLY_RESET;
			degree_q <= DEGREE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_GENERATOR_POLY: poly_q   <= cfg_wdata;
				CFG_CRC_DEGREE:     degree_q <= cfg_wdata[DEG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		deg_eff = degree_q;
		if (deg_eff == '0)
			deg_eff = DEG_W'(1);
		if (deg_eff > NCELL_D)
			deg_eff = NCELL_D;
	end

	assign top_idx = deg_eff - DEG_W'(1);

	always_comb begin
		for (int i = 0; i < NCELL; i++) begin
			mask[i] = (DEG_W'(i) < deg_eff);
		end
	end

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign ctrl.en  = accept;
	assign ctrl.clr = s_axis_tlast;
	assign ctrl.fb  = rem_vec[top_idx[IDX_W-1:0]] ^ s_axis_tdata[0];

	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		logic sin;
		if (g == 0) begin : g_first
			assign sin = 1'b0;
		end else begin : g_rest
			assign sin = rem_vec[g-1];
		end
		pcrc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.poly_bit (poly_q[g]),
			.mask_bit (mask[g]),
			.shift_in (sin),
			.rem_bit  (rem_vec[g]),
			.next_bit (next_vec[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && s_axis_tlast) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && s_axis_tlast) begin
			out_rem_q  <= REM_W'(next_vec);
			out_zero_q <= (next_vec == '0);
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_rem_q;
	assign m_axis_tuser[0] = out_zero_q;

endmodule

`default_nettype wire
